@@ rtl/core/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Width of the phase counter and of the timing registers
  localparam int CNT_W    = 16;
  // Byte address width of the configuration port (two 32-bit registers)
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Register indexes
  localparam logic REG_HALF  = 1'b0;
  localparam logic REG_SETUP = 1'b1;

  // Reset values of the timing registers
  localparam logic [CNT_W-1:0] HALF_RST  = CNT_W'(5);
  localparam logic [CNT_W-1:0] SETUP_RST = CNT_W'(3);

  // Command codes
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_SACK   = 3'd5;
  localparam logic [2:0] CMD_GACK   = 3'd6;
  // Unused code: ignored when idle, rejected when busy
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Input word: one timing tick
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_in;
  } in_word_t;

  // Result word: drive levels and status after the tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;
  } out_word_t;

  // Classified tick as held in the queue between front and back
  typedef struct packed {
    logic [2:0] op;        // valid command, CMD_NONE for none or unknown
    logic       cmd_any;   // any nonzero command code, for rejection
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_in;
  } tick_t;

  // Timing values handed from the register file to the engine
  typedef struct packed {
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] setup;
  } timing_t;

endpackage

@@ rtl/core/i2cm_front.sv @@
// Front end of the I2C master bit engine: classifies each incoming tick
// and holds it in a two-entry queue for the engine. Uses i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cm_pkg::in_word_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output i2cm_pkg::tick_t   q_data
);
  import i2cm_pkg::*;

  tick_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  tick_t      cls;

  // Classify the command: map the unused code to no command
  always_comb begin
    cls.op         = (in_data.command == CMD_UNUSED) ? CMD_NONE : in_data.command;
    cls.cmd_any    = (in_data.command != CMD_NONE);
    cls.write_data = in_data.write_data;
    cls.ack_level  = in_data.ack_level;
    cls.sda_in     = in_data.sda_in;
  end

  // Queue control
  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/core/i2cm_back.sv @@
// Back end of the I2C master bit engine: runs the SCL/SDA phase sequencer
// one tick per queued word and registers the result word. Uses i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  i2cm_pkg::timing_t  timing,
  input  logic               q_valid,
  output logic               q_pop,
  input  i2cm_pkg::tick_t    q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cm_pkg::out_word_t out_data
);
  import i2cm_pkg::*;

  // Sequencer steps
  localparam logic [4:0] ST_IDLE         = 5'd0;
  localparam logic [4:0] ST_START_SDA_HI = 5'd1;
  localparam logic [4:0] ST_START_SCL_HI = 5'd2;
  localparam logic [4:0] ST_START_SDA_LO = 5'd3;
  localparam logic [4:0] ST_START_END    = 5'd4;
  localparam logic [4:0] ST_STOP_SDA_LO  = 5'd5;
  localparam logic [4:0] ST_STOP_SCL_HI  = 5'd6;
  localparam logic [4:0] ST_STOP_SDA_HI  = 5'd7;
  localparam logic [4:0] ST_STOP_END     = 5'd8;
  localparam logic [4:0] ST_SACK_SDA     = 5'd9;
  localparam logic [4:0] ST_SACK_SCL_HI  = 5'd10;
  localparam logic [4:0] ST_SACK_END     = 5'd11;
  localparam logic [4:0] ST_GACK_SCL_HI  = 5'd12;
  localparam logic [4:0] ST_GACK_SAMPLE  = 5'd13;
  localparam logic [4:0] ST_WR_SDA       = 5'd14;
  localparam logic [4:0] ST_WR_SCL_HI    = 5'd15;
  localparam logic [4:0] ST_WR_BIT_END   = 5'd16;
  localparam logic [4:0] ST_RD_SCL_HI    = 5'd17;
  localparam logic [4:0] ST_RD_SAMPLE    = 5'd18;

  typedef struct packed {
    logic [4:0]       step;
    logic [CNT_W-1:0] cnt;
    logic [3:0]       bit_idx;
    logic [7:0]       shift;
    logic [7:0]       rx;
    logic             ack;
    logic             scl;
    logic             sda;
    logic             done;
  } eng_t;

  eng_t             eng_r, eng_nxt;
  eng_t             e0, e1, e2;
  logic [CNT_W-1:0] h, s;
  logic             busy;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Run the step whose hold has expired
  function automatic eng_t advance(eng_t e, logic [CNT_W-1:0] hl, logic [CNT_W-1:0] sl,
                                   logic sda_in);
    eng_t r;
    r      = e;
    r.done = 1'b0;
    if (e.step != ST_IDLE && e.cnt == '0) begin
      unique case (e.step)
        ST_START_SDA_HI: begin r.sda = 1'b1; r.cnt = hl; r.step = ST_START_SCL_HI; end
        ST_START_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_START_SDA_LO; end
        ST_START_SDA_LO: begin r.sda = 1'b0; r.cnt = hl; r.step = ST_START_END; end
        ST_START_END: begin
          r.scl = 1'b0; r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
        end
        ST_STOP_SDA_LO: begin r.sda = 1'b0; r.cnt = hl; r.step = ST_STOP_SCL_HI; end
        ST_STOP_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_STOP_SDA_HI; end
        ST_STOP_SDA_HI: begin r.sda = 1'b1; r.cnt = hl; r.step = ST_STOP_END; end
        ST_STOP_END: begin
          r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
        end
        ST_SACK_SDA: begin
          r.sda = e.shift[0]; r.cnt = hl - sl; r.step = ST_SACK_SCL_HI;
        end
        ST_SACK_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_SACK_END; end
        ST_SACK_END: begin
          r.scl = 1'b0; r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
        end
        ST_GACK_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_GACK_SAMPLE; end
        ST_GACK_SAMPLE: begin
          r.ack = sda_in; r.scl = 1'b0;
          r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
        end
        ST_WR_SDA: begin
          r.sda = e.shift[7]; r.cnt = hl - sl; r.step = ST_WR_SCL_HI;
        end
        ST_WR_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_WR_BIT_END; end
        ST_WR_BIT_END: begin
          r.shift   = {e.shift[6:0], 1'b0};
          r.bit_idx = e.bit_idx + 4'd1;
          r.scl     = 1'b0;
          if (r.bit_idx < 4'd8) begin
            r.cnt = sl; r.step = ST_WR_SDA;
          end else begin
            r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
          end
        end
        ST_RD_SCL_HI: begin r.scl = 1'b1; r.cnt = hl; r.step = ST_RD_SAMPLE; end
        ST_RD_SAMPLE: begin
          r.shift   = {e.shift[6:0], sda_in};
          r.bit_idx = e.bit_idx + 4'd1;
          r.scl     = 1'b0;
          if (r.bit_idx < 4'd8) begin
            r.cnt = hl; r.step = ST_RD_SCL_HI;
          end else begin
            r.rx = r.shift; r.step = ST_IDLE; r.cnt = '0; r.done = 1'b1;
          end
        end
        default: begin
          r.step = ST_IDLE; r.cnt = '0;
        end
      endcase
    end
    return r;
  endfunction

  // Effective half period and clamped setup
  always_comb begin
    h = (timing.half == '0) ? CNT_W'(1) : timing.half;
    s = (timing.setup > h) ? h : timing.setup;
  end

  assign busy = (eng_r.step != ST_IDLE);

  // Count down while busy, otherwise dispatch a new command
  always_comb begin
    e0      = eng_r;
    e0.done = 1'b0;
    if (busy) begin
      if (eng_r.cnt != '0) begin
        e0.cnt = eng_r.cnt - CNT_W'(1);
      end
    end else begin
      e0.bit_idx = 4'd0;
      unique case (q_data.op)
        CMD_START: begin e0.scl = 1'b0; e0.cnt = h; e0.step = ST_START_SDA_HI; end
        CMD_STOP:  begin e0.scl = 1'b0; e0.cnt = h; e0.step = ST_STOP_SDA_LO; end
        CMD_WRITE: begin
          e0.scl = 1'b0; e0.shift = q_data.write_data; e0.cnt = s; e0.step = ST_WR_SDA;
        end
        CMD_READ: begin
          e0.scl = 1'b0; e0.sda = 1'b1; e0.shift = 8'd0; e0.cnt = h;
          e0.step = ST_RD_SCL_HI;
        end
        CMD_SACK: begin
          e0.scl = 1'b0; e0.shift = {7'd0, q_data.ack_level}; e0.cnt = s;
          e0.step = ST_SACK_SDA;
        end
        CMD_GACK: begin
          e0.scl = 1'b0; e0.sda = 1'b1; e0.cnt = h; e0.step = ST_GACK_SCL_HI;
        end
        default: begin
        end
      endcase
    end
    // At most one zero-length hold can follow an expired one within a tick
    e1 = advance(e0, h, s, q_data.sda_in);
    e2 = advance(e1, h, s, q_data.sda_in);
  end

  // Take a queued tick whenever the result register is free or draining
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    eng_nxt      = e2;
    eng_nxt.done = 1'b0;
    out_nxt.scl_level = e2.scl;
    out_nxt.sda_level = e2.sda;
    out_nxt.busy_res  = (e2.step != ST_IDLE);
    out_nxt.done_res  = e1.done | e2.done;
    out_nxt.read_data = e2.rx;
    out_nxt.ack_seen  = e2.ack;
    out_nxt.rejected  = busy && q_data.cmd_any;
    out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r.step    <= ST_IDLE;
      eng_r.cnt     <= '0;
      eng_r.bit_idx <= 4'd0;
      eng_r.shift   <= 8'd0;
      eng_r.rx      <= 8'd0;
      eng_r.ack     <= 1'b0;
      eng_r.scl     <= 1'b1;
      eng_r.sda     <= 1'b1;
      eng_r.done    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        eng_r <= eng_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/i2c_master_bit_engine_core.sv @@
// I2C master bit engine, one input word per timing tick and one result word
// per input word. The engine sustains one word per clock cycle while the
// output is not stalled: the phase sequencer in the back end advances by one
// tick each cycle it takes a word, chaining a zero-length setup hold within
// the same cycle. A two-entry queue sits between the command front end and
// the sequencer, and the result word leaves from a register, so an accepted
// word passes through a queue entry and then the result register. Timing
// registers: half period at byte 0, data setup at byte 4; write them only
// while no words are in flight. Depends on i2cm_pkg, i2cm_front and i2cm_back.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  i2cm_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output i2cm_pkg::out_word_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0] paddr,
  input  logic [i2cm_pkg::CFG_DW-1:0] pwdata,
  output logic [i2cm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import i2cm_pkg::*;

  logic [CNT_W-1:0] half_r, setup_r;
  logic             wr_en;
  logic             reg_sel;
  timing_t          timing;
  logic             q_valid, q_pop;
  tick_t            q_data;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_RST;
      setup_r <= SETUP_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_HALF) begin
        half_r <= pwdata[CNT_W-1:0];
      end else begin
        setup_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_SETUP) begin
      prdata[CNT_W-1:0] = setup_r;
    end else begin
      prdata[CNT_W-1:0] = half_r;
    end
  end

  assign timing.half  = half_r;
  assign timing.setup = setup_r;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .timing    (timing),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
